### hdl/wf3_pkg.sv
// ----------------------------------------------------------------------------
// wf3_pkg: shared definitions for the 3x3 window filter
// Field widths, register indexes, filter modes, arithmetic constants and the
// frame size clamp used by the filter core.
// ----------------------------------------------------------------------------
package wf3_pkg;

    localparam int PIX_W          = 8;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int THRESH_W       = 15;
    localparam int MODE_W         = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 15;
    localparam int OUT_ROW_W      = 12;
    localparam int OUT_COL_W      = 10;

    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_HEIGHT   = 4096;
    localparam int RST_FRAME_WIDTH  = 640;
    localparam int RST_FRAME_HEIGHT = 480;
    localparam logic [THRESH_W-1:0] RST_THRESH = 15'd200;

    localparam int WIN_TAPS = 9;
    localparam int SUM_W    = 12;
    localparam int MAG_W    = PIX_W - 1;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SQSUM_W  = SQ_W + 1;

    // Division by 9 of a sum below 2296 as a multiply by ceil(2^16 / 9).
    localparam int DIV9_W     = 13;
    localparam int DIV9_SHIFT = 16;
    localparam logic [DIV9_W-1:0] DIV9_RECIP = 13'd7282;

    localparam logic [PIX_W+1:0] EMBOSS_BIAS = 10'd256;
    localparam logic [PIX_W-1:0] EDGE_ON     = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF    = 8'd0;

    localparam int FIFO_DEPTH = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_FILTER_MODE    = 2'd2,
        CFG_EDGE_THRESHOLD = 2'd3
    } t_cfg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_BLUR   = 2'd0,
        MODE_EMBOSS = 2'd1,
        MODE_EDGE   = 2'd2
    } t_filter_mode;

    // A size of zero counts as one; sizes above the maximum saturate.
    function automatic int clamp_size(int v, int maxv);
        int res;
        if (v == 0) begin
            res = 1;
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

### hdl/window_filter_3x3_core.sv
// ----------------------------------------------------------------------------
// window_filter_3x3_core: streaming 3x3 window filter on 8-bit grey pixels
// Box blur, emboss or gradient threshold on interior pixels, border copy on
// the first and last rows and columns, results tagged with row and column.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on i_pixel_in with i_valid/o_stall; a transfer
// happens when i_valid is high and o_stall is low. Results leave on o_valid/
// i_stall with the same rule. Each pixel causes zero to three results: the
// window center one row and one column behind it, the right border pixel of
// the row above, and on the last row the pixel itself.
// Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data while idle,
// a rule left to the user, as the block has no check. Pixels travel through
// three stages: line memory read, window update with adder and difference
// logic, then the multipliers. The two buffered lines live in one memory of
// MAX_WIDTH words, read and written once per pixel, so one pixel is accepted
// per cycle as long as the output keeps up; pixels of the last row and column
// give more than one result, and then the output port sets the rate. A result
// queue of eight pixel entries sits in front of the output; o_stall rises
// when its entries and the pixels in flight fill it, so a stalled receiver
// backs up into the input. Reset clears the counters, window and queue and
// loads the register defaults; no clearing pass runs.
// ----------------------------------------------------------------------------
module window_filter_3x3_core
    import wf3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [PIX_W-1:0]      i_pixel_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic [OUT_ROW_W-1:0]  o_out_row,
    output logic [OUT_COL_W-1:0]  o_out_col,
    output logic                  o_last_of_run,
    output logic                  o_last_of_frame,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int OCC_W = CNT_W + 1;
    localparam int PROD_W = SUM_W + DIV9_W;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             row_ge1;
        logic             row_ge2;
        logic             emit_a;
        logic             emit_b;
        logic             emit_c;
        logic             border;
        logic             last_frame;
        logic [PIX_W-1:0] above1;
        logic [PIX_W-1:0] pix;
    } t_item;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             emit_a;
        logic             emit_b;
        logic             emit_c;
        logic             last_frame;
        logic [PIX_W-1:0] val_a;
        logic [PIX_W-1:0] val_b;
        logic [PIX_W-1:0] val_c;
    } t_entry;

    logic [COL_W-1:0]    r_col_last;
    logic [ROW_W-1:0]    r_row_last;
    logic [MODE_W-1:0]   r_mode;
    logic [THRESH_W-1:0] r_thresh;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic             col_end;
    logic             row_end;
    logic             in_accept;
    t_item            acc_item;

    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_line_rd;
    logic [2*PIX_W-1:0] r_fwd_data;
    logic               r_fwd_hit;
    logic [2*PIX_W-1:0] line_rdata;
    logic [2*PIX_W-1:0] line_wdata;
    logic [PIX_W-1:0]   above1;
    logic [PIX_W-1:0]   above2;

    logic [PIX_W-1:0] r_win [WIN_TAPS];
    logic [PIX_W-1:0] nw [WIN_TAPS];
    logic [SUM_W-1:0] win_sum;
    logic [PIX_W+1:0] emb_sum;
    logic [PIX_W:0]   diff_x;
    logic [PIX_W:0]   diff_y;
    logic [PIX_W:0]   abs_x;
    logic [PIX_W:0]   abs_y;

    logic             r_p1_valid;
    logic             r_p2_valid;
    logic             r_p3_valid;
    t_item            r_p1;
    t_item            p1_fwd;
    t_item            r_p2;
    t_item            r_p3;
    logic [SUM_W-1:0] r_p2_sum;
    logic [PIX_W-1:0] r_p2_emb;
    logic [PIX_W-1:0] r_p2_center;
    logic [MAG_W-1:0] r_p2_mag_x;
    logic [MAG_W-1:0] r_p2_mag_y;
    logic [PIX_W-1:0] r_p3_blur;
    logic [PIX_W-1:0] r_p3_emb;
    logic [PIX_W-1:0] r_p3_center;
    logic [SQ_W-1:0]  r_p3_sq_x;
    logic [SQ_W-1:0]  r_p3_sq_y;
    logic [PROD_W-1:0] blur_prod;
    logic [SQSUM_W-1:0] sq_sum;
    logic [PIX_W-1:0]  filt_val;
    t_entry            push_entry;
    logic              push;

    t_entry           r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [OCC_W-1:0] occ;
    t_entry           head;
    logic [2:0]       r_done;
    logic [2:0]       pend;
    logic [2:0]       sel;
    logic [ROW_W-1:0] row_dec;
    logic [COL_W-1:0] col_dec;
    logic             out_xfer;
    logic             pop;

    // Configuration registers hold the clamped last column and row index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= COL_W'(clamp_size(RST_FRAME_WIDTH, MAX_WIDTH) - 1);
            r_row_last <= ROW_W'(clamp_size(RST_FRAME_HEIGHT, MAX_HEIGHT) - 1);
            r_mode     <= MODE_BLUR;
            r_thresh   <= RST_THRESH;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_WIDTH: begin
                    r_col_last <= COL_W'(clamp_size(int'(i_cfg_data[FRAME_WIDTH_W-1:0]),
                                                    MAX_WIDTH) - 1);
                end
                CFG_FRAME_HEIGHT: begin
                    r_row_last <= ROW_W'(clamp_size(int'(i_cfg_data[FRAME_HEIGHT_W-1:0]),
                                                    MAX_HEIGHT) - 1);
                end
                CFG_FILTER_MODE: begin
                    r_mode <= i_cfg_data[MODE_W-1:0];
                end
                CFG_EDGE_THRESHOLD: begin
                    r_thresh <= i_cfg_data[THRESH_W-1:0];
                end
            endcase
        end
    end

    assign occ = OCC_W'(r_count) + OCC_W'(r_p1_valid) + OCC_W'(r_p2_valid)
               + OCC_W'(r_p3_valid);
    assign o_stall   = occ >= OCC_W'(FIFO_DEPTH);
    assign in_accept = i_valid && !o_stall;

    assign cur_col = (r_col > r_col_last) ? r_col_last : r_col;
    assign cur_row = (r_row > r_row_last) ? r_row_last : r_row;
    assign col_end = cur_col == r_col_last;
    assign row_end = cur_row == r_row_last;

    always_comb begin
        acc_item            = '0;
        acc_item.row        = cur_row;
        acc_item.col        = cur_col;
        acc_item.row_ge1    = cur_row != '0;
        acc_item.row_ge2    = cur_row >= ROW_W'(2);
        acc_item.emit_a     = (cur_row != '0) && (cur_col != '0);
        acc_item.emit_b     = (cur_row != '0) && col_end;
        acc_item.emit_c     = row_end;
        acc_item.border     = (cur_row == ROW_W'(1)) || (cur_col == COL_W'(1));
        acc_item.last_frame = col_end;
        acc_item.pix        = i_pixel_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : cur_row + ROW_W'(1);
            end else begin
                r_col <= cur_col + COL_W'(1);
                r_row <= cur_row;
            end
        end
    end

    // Each word holds the row above in the low byte and the row two above
    // in the high byte. A read that meets the write of the previous pixel
    // at the same address takes the write data instead.
    always_ff @(posedge i_clk) begin
        if (r_p1_valid) begin
            line_mem[r_p1.col] <= line_wdata;
        end
        if (in_accept) begin
            r_line_rd <= line_mem[cur_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_fwd_hit  <= r_p1_valid && (r_p1.col == cur_col);
            r_fwd_data <= line_wdata;
        end
    end

    assign line_rdata = r_fwd_hit ? r_fwd_data : r_line_rd;
    assign above1     = r_p1.row_ge1 ? line_rdata[PIX_W-1:0] : '0;
    assign above2     = r_p1.row_ge2 ? line_rdata[2*PIX_W-1:PIX_W] : '0;
    assign line_wdata = {above1, r_p1.pix};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nw[i*3+0] = r_win[i*3+1];
            nw[i*3+1] = r_win[i*3+2];
        end
        nw[2] = above2;
        nw[5] = above1;
        nw[8] = r_p1.pix;
        win_sum = '0;
        for (int i = 0; i < WIN_TAPS; i++) begin
            win_sum = win_sum + SUM_W'(nw[i]);
        end
    end

    assign emb_sum = {2'b00, nw[0]} + EMBOSS_BIAS - {2'b00, nw[8]};
    assign diff_x  = {1'b0, nw[5]} - {1'b0, nw[3]};
    assign diff_y  = {1'b0, nw[7]} - {1'b0, nw[1]};
    assign abs_x   = diff_x[PIX_W] ? -diff_x : diff_x;
    assign abs_y   = diff_y[PIX_W] ? -diff_y : diff_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_TAPS; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_p1_valid) begin
            for (int i = 0; i < WIN_TAPS; i++) begin
                r_win[i] <= nw[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
        end else begin
            r_p1_valid <= in_accept;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
        end
    end

    assign blur_prod = {{DIV9_W{1'b0}}, r_p2_sum} * {{SUM_W{1'b0}}, DIV9_RECIP};

    always_comb begin
        p1_fwd        = r_p1;
        p1_fwd.above1 = above1;
    end

    always_ff @(posedge i_clk) begin
        r_p1 <= acc_item;

        r_p2        <= p1_fwd;
        r_p2_sum    <= win_sum;
        r_p2_emb    <= emb_sum[PIX_W:1];
        r_p2_center <= nw[4];
        r_p2_mag_x  <= abs_x[MAG_W:1];
        r_p2_mag_y  <= abs_y[MAG_W:1];

        r_p3        <= r_p2;
        r_p3_blur   <= blur_prod[DIV9_SHIFT+PIX_W-1:DIV9_SHIFT];
        r_p3_emb    <= r_p2_emb;
        r_p3_center <= r_p2_center;
        r_p3_sq_x   <= {{MAG_W{1'b0}}, r_p2_mag_x} * {{MAG_W{1'b0}}, r_p2_mag_x};
        r_p3_sq_y   <= {{MAG_W{1'b0}}, r_p2_mag_y} * {{MAG_W{1'b0}}, r_p2_mag_y};
    end

    assign sq_sum = {1'b0, r_p3_sq_x} + {1'b0, r_p3_sq_y};

    always_comb begin
        case (r_mode)
            MODE_BLUR:   filt_val = r_p3_blur;
            MODE_EMBOSS: filt_val = r_p3_emb;
            MODE_EDGE:   filt_val = (sq_sum > r_thresh) ? EDGE_ON : EDGE_OFF;
            default:     filt_val = r_p3_center;
        endcase
    end

    always_comb begin
        push_entry            = '0;
        push_entry.row        = r_p3.row;
        push_entry.col        = r_p3.col;
        push_entry.emit_a     = r_p3.emit_a;
        push_entry.emit_b     = r_p3.emit_b;
        push_entry.emit_c     = r_p3.emit_c;
        push_entry.last_frame = r_p3.last_frame;
        push_entry.val_a      = r_p3.border ? r_p3_center : filt_val;
        push_entry.val_b      = r_p3.above1;
        push_entry.val_c      = r_p3.pix;
    end

    assign push = r_p3_valid && (r_p3.emit_a || r_p3.emit_b || r_p3.emit_c);

    // Result queue: one entry per pixel with results, up to three results in each.
    assign head     = r_fifo[r_rd_ptr];
    assign o_valid  = r_count != '0;
    assign pend     = {head.emit_c, head.emit_b, head.emit_a} & ~r_done;
    assign sel[0]   = pend[0];
    assign sel[1]   = !pend[0] && pend[1];
    assign sel[2]   = !pend[0] && !pend[1];
    assign row_dec  = head.row - ROW_W'(1);
    assign col_dec  = head.col - COL_W'(1);
    assign out_xfer = o_valid && !i_stall;
    assign pop      = out_xfer && o_last_of_run;

    always_comb begin
        if (sel[0]) begin
            o_pixel_out     = head.val_a;
            o_out_row       = OUT_ROW_W'(row_dec);
            o_out_col       = OUT_COL_W'(col_dec);
            o_last_of_run   = pend[2:1] == 2'b00;
            o_last_of_frame = 1'b0;
        end else if (sel[1]) begin
            o_pixel_out     = head.val_b;
            o_out_row       = OUT_ROW_W'(row_dec);
            o_out_col       = OUT_COL_W'(head.col);
            o_last_of_run   = !pend[2];
            o_last_of_frame = 1'b0;
        end else begin
            o_pixel_out     = head.val_c;
            o_out_row       = OUT_ROW_W'(head.row);
            o_out_col       = OUT_COL_W'(head.col);
            o_last_of_run   = 1'b1;
            o_last_of_frame = head.last_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_done   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (pop) begin
                r_done <= '0;
            end else if (out_xfer) begin
                r_done <= r_done | sel;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> (r_count < CNT_W'(FIFO_DEPTH)))
        else $error("result queue written while full");

    a_room_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ <= OCC_W'(FIFO_DEPTH))
        else $error("pixels in flight exceed free queue entries");

    a_head_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (pend != 3'b000))
        else $error("queue head has no result left to transfer");

    a_done_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_done == 3'b000))
        else $error("result progress not cleared after the last result of a pixel");

endmodule

### verif/wf3_checker.sv
// ----------------------------------------------------------------------------
// wf3_checker: prediction and comparison for the 3x3 window filter core
// Watches register writes and both pixel channels, keeps its own copy of
// the counters, window and two buffered lines, works out the results of
// each accepted pixel and compares every result transfer against them in
// order. It reports the number of mismatches and of results still owed.
// ----------------------------------------------------------------------------
module wf3_checker
    import wf3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [PIX_W-1:0]      i_pixel_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [PIX_W-1:0]      i_pixel_out,
    input  logic [OUT_ROW_W-1:0]  i_out_row,
    input  logic [OUT_COL_W-1:0]  i_out_col,
    input  logic                  i_last_of_run,
    input  logic                  i_last_of_frame,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending
);

    typedef struct packed {
        logic [PIX_W-1:0]     pix;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 last_run;
        logic                 last_frame;
    } t_pixel_result;

    logic [FRAME_WIDTH_W-1:0]  width_reg;
    logic [FRAME_HEIGHT_W-1:0] height_reg;
    logic [MODE_W-1:0]         mode_reg;
    logic [THRESH_W-1:0]       thresh_reg;

    logic [PIX_W-1:0] line_mem [2*MAX_WIDTH];
    logic [PIX_W-1:0] win [WIN_TAPS];
    int               row_cnt;
    int               col_cnt;

    t_pixel_result pending_pixels [$];
    int            mismatch_count = 0;

    function automatic logic [PIX_W-1:0] interior_value();
        int sum;
        int dx;
        int dy;
        sum = 0;
        case (mode_reg)
            MODE_BLUR: begin
                for (int k = 0; k < WIN_TAPS; k++) begin
                    sum += int'(win[k]);
                end
                return PIX_W'(sum / 9);
            end
            MODE_EMBOSS: begin
                return PIX_W'((int'(win[0]) - int'(win[8]) + 256) / 2);
            end
            MODE_EDGE: begin
                dx = (int'(win[5]) - int'(win[3])) / 2;
                dy = (int'(win[7]) - int'(win[1])) / 2;
                return (dx * dx + dy * dy > int'(thresh_reg)) ? EDGE_ON : EDGE_OFF;
            end
            default: begin
                return win[4];
            end
        endcase
    endfunction

    function automatic t_pixel_result make_result(logic [PIX_W-1:0] pix, int row, int col,
                                                  logic at_frame_end);
        t_pixel_result res;
        res.pix        = pix;
        res.row        = OUT_ROW_W'(row);
        res.col        = OUT_COL_W'(col);
        res.last_run   = 1'b0;
        res.last_frame = at_frame_end;
        return res;
    endfunction

    task automatic absorb_pixel(input logic [PIX_W-1:0] pix);
        int               w;
        int               h;
        int               r;
        int               c;
        int               n;
        logic [PIX_W-1:0] up1;
        logic [PIX_W-1:0] up2;
        t_pixel_result    res [3];
        w = int'(width_reg);
        h = int'(height_reg);
        if (w == 0) w = 1;
        else if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h == 0) h = 1;
        else if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        r = (row_cnt >= h) ? h - 1 : row_cnt;
        c = (col_cnt >= w) ? w - 1 : col_cnt;

        up1 = (r >= 1) ? line_mem[c] : '0;
        up2 = (r >= 2) ? line_mem[MAX_WIDTH + c] : '0;
        for (int k = 0; k < 3; k++) begin
            win[k*3]   = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2] = up2;
        win[5] = up1;
        win[8] = pix;
        line_mem[MAX_WIDTH + c] = up1;
        line_mem[c]             = pix;

        // The window center is a border copy on the first row or column.
        n = 0;
        if (r >= 1 && c >= 1) begin
            res[n] = make_result((r == 1 || c == 1) ? win[4] : interior_value(),
                                 r - 1, c - 1, 1'b0);
            n++;
        end
        if (r >= 1 && c == w - 1) begin
            res[n] = make_result(up1, r - 1, c, 1'b0);
            n++;
        end
        if (r == h - 1) begin
            res[n] = make_result(pix, r, c, c == w - 1);
            n++;
        end
        if (n > 0) res[n-1].last_run = 1'b1;
        for (int k = 0; k < n; k++) begin
            pending_pixels.push_back(res[k]);
        end

        if (c + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
            row_cnt = r;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result();
        t_pixel_result want;
        if (pending_pixels.size() == 0) begin
            $error("result for row %0d col %0d arrived with nothing outstanding",
                   i_out_row, i_out_col);
            mismatch_count++;
        end else begin
            want = pending_pixels.pop_front();
            check_field("pixel_out", 16'(want.pix), 16'(i_pixel_out));
            check_field("out_row", 16'(want.row), 16'(i_out_row));
            check_field("out_col", 16'(want.col), 16'(i_out_col));
            check_field("last_of_run", 16'(want.last_run), 16'(i_last_of_run));
            check_field("last_of_frame", 16'(want.last_frame), 16'(i_last_of_frame));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = FRAME_WIDTH_W'(RST_FRAME_WIDTH);
            height_reg = FRAME_HEIGHT_W'(RST_FRAME_HEIGHT);
            mode_reg   = MODE_BLUR;
            thresh_reg = RST_THRESH;
            win        = '{default: '0};
            row_cnt    = 0;
            col_cnt    = 0;
            pending_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_WIDTH:    width_reg  = i_cfg_data[FRAME_WIDTH_W-1:0];
                    CFG_FRAME_HEIGHT:   height_reg = i_cfg_data[FRAME_HEIGHT_W-1:0];
                    CFG_FILTER_MODE:    mode_reg   = i_cfg_data[MODE_W-1:0];
                    CFG_EDGE_THRESHOLD: thresh_reg = i_cfg_data[THRESH_W-1:0];
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_pixel(i_pixel_in);
            end
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= pending_pixels.size();
    end

endmodule

### verif/window_filter_3x3_core_test.sv
// ----------------------------------------------------------------------------
// window_filter_3x3_core_test: regression for the 3x3 window filter core
// Programs frame sizes, filter modes and thresholds between frames, streams
// directed tiles for each filter, size extremes, mid-frame shrinks, a frame
// with no gaps and no stalls, then random frames, with random gaps on the
// input and random stalls on the output. A separate checker predicts and
// compares.
// ----------------------------------------------------------------------------
module window_filter_3x3_core_test;
    import wf3_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_PIXELS  = 80;
    localparam int STEADY_WIDTH   = 16;
    localparam int STEADY_HEIGHT  = 4;
    localparam int THRESH_MAX     = 2**THRESH_W - 1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [PIX_W-1:0]      i_pixel_in = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [PIX_W-1:0]      o_pixel_out;
    logic [OUT_ROW_W-1:0]  o_out_row;
    logic [OUT_COL_W-1:0]  o_out_col;
    logic                  o_last_of_run;
    logic                  o_last_of_frame;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic steady = 1'b0;
    int   idle_cycles = 0;
    int   mismatches;
    int   pending_results;
    int   random_sent;

    window_filter_3x3_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_pixel_in      (i_pixel_in),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_out     (o_pixel_out),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_last_of_run   (o_last_of_run),
        .o_last_of_frame (o_last_of_frame),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    wf3_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_pixel_in      (i_pixel_in),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_pixel_out     (o_pixel_out),
        .i_out_row       (o_out_row),
        .i_out_col       (o_out_col),
        .i_last_of_run   (o_last_of_run),
        .i_last_of_frame (o_last_of_frame),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_mismatches    (mismatches),
        .o_pending       (pending_results)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < 32);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int frame_pixels(int w, int h);
        int wc;
        int hc;
        wc = (w == 0) ? 1 : ((w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w);
        hc = (h == 0) ? 1 : ((h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h);
        return wc * hc;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom());
        endcase
    endfunction

    function automatic int pick_size(int common_hi, int rare_hi);
        case ($urandom_range(9))
            0:       return 0;
            1:       return $urandom_range(rare_hi, common_hi + 1);
            default: return $urandom_range(common_hi, 1);
        endcase
    endfunction

    function automatic int pick_threshold();
        case ($urandom_range(3))
            0:       return 0;
            1:       return THRESH_MAX;
            2:       return $urandom_range(2000, 0);
            default: return $urandom_range(THRESH_MAX, 0);
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        while (!steady && $urandom_range(99) < 32) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_random(input int count);
        for (int k = 0; k < count; k++) begin
            send_pixel(pick_pixel());
        end
    endtask

    task automatic send_tile(input logic [9*PIX_W-1:0] tile);
        for (int k = 8; k >= 0; k--) begin
            send_pixel(tile[k*PIX_W +: PIX_W]);
        end
    endtask

    // Pixels that only fill the line buffers give no result, so settle lets
    // the pipeline drain once nothing is owed before the core counts as idle.
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
    endtask

    task automatic program_filter(input int w, input int h, input int mode, input int thr);
        settle();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_FILTER_MODE, mode);
        write_reg(CFG_EDGE_THRESHOLD, thr);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int w;
        int h;
        int frames;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        program_filter(3, 3, MODE_BLUR, THRESH_MAX);
        send_tile({9{8'hFF}});
        program_filter(3, 3, MODE_EMBOSS, 0);
        send_tile({8'd0, 8'd50, 8'd60, 8'd70, 8'd80, 8'd90, 8'd100, 8'd110, 8'd255});
        // Odd negative differences must truncate toward zero, leaving no edge.
        program_filter(3, 3, MODE_EDGE, 0);
        send_tile({8'd0, 8'd1, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});

        program_filter(0, 3, MODE_EDGE, 50);
        send_random(6);
        program_filter(5, 0, MODE_EMBOSS, 0);
        send_random(10);

        program_filter(3, 2**FRAME_HEIGHT_W - 1, MODE_BLUR, 0);
        send_random(15);
        settle();
        write_reg(CFG_FRAME_HEIGHT, 3);
        i_cfg_we <= 1'b0;
        send_random(3);

        program_filter(6, 4, MODE_EDGE, 300);
        send_random(11);
        settle();
        write_reg(CFG_FRAME_WIDTH, 3);
        i_cfg_we <= 1'b0;
        send_random(7);

        program_filter(STEADY_WIDTH, STEADY_HEIGHT, $urandom_range(3, 0), pick_threshold());
        steady <= 1'b1;
        send_random(frame_pixels(STEADY_WIDTH, STEADY_HEIGHT));
        settle();
        steady <= 1'b0;

        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            w = pick_size(10, 24);
            h = pick_size(6, 8);
            frames = $urandom_range(2, 1);
            program_filter(w, h, $urandom_range(3, 0), pick_threshold());
            send_random(frames * frame_pixels(w, h));
            random_sent += frames * frame_pixels(w, h);
        end
        settle();

        if (mismatches == 0 && pending_results == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            if (pending_results != 0) begin
                $error("%0d expected results never arrived", pending_results);
            end
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
